[rtl/affine_point_box_transform_defines.svh]
// Assertion macros for the affine point and box transform.
`ifndef AFFINE_POINT_BOX_TRANSFORM_DEFINES_SVH
`define AFFINE_POINT_BOX_TRANSFORM_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define APBT_ASSERT_NOW(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle.
`define APBT_ASSERT_NEXT(lbl, cond, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

[rtl/apbt_pkg.sv]
// Shared types and constants for the affine point and box transform.
`default_nettype none

package apbt_pkg;

   localparam int COORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   localparam int OP_BITS        = 2;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [OP_BITS-1:0] {
      OP_POINT = 2'd0,
      OP_DIST  = 2'd1,
      OP_BOX   = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_COEF_A  = 3'd0,
      REG_COEF_B  = 3'd1,
      REG_COEF_C  = 3'd2,
      REG_COEF_D  = 3'd3,
      REG_SHIFT_X = 3'd4,
      REG_SHIFT_Y = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

[rtl/affine_point_box_transform.sv]
// Six-stage pipelined 2D affine transform of points, distances and boxes.
`default_nettype none
`include "affine_point_box_transform_defines.svh"

// Takes one request per clock while no response is stalled and returns one
// response per request, in order. The pipeline is: split multiplies (eight
// coefficient-by-operand products, each as two half-width partials), partial
// combine with floor to the fraction width, linear sum plus translation (not
// for distances), box corners, corner min/max, and a final width/height
// subtract with saturation into the response register. A stalled response
// freezes every stage, so req_stall follows rsp_stall while a response is
// held. Coefficients and translation are read live from the csr registers;
// write them only while no request is in flight. Opcode 3 returns all zeros.
module affine_point_box_transform #(
   parameter int COORD_BITS = apbt_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = apbt_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [apbt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [COORD_BITS-1:0]               csr_data,

   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [apbt_pkg::OP_BITS-1:0]        req_opcode,
   input  wire logic signed [COORD_BITS-1:0]        req_x_in,
   input  wire logic signed [COORD_BITS-1:0]        req_y_in,
   input  wire logic signed [COORD_BITS-1:0]        req_width_in,
   input  wire logic signed [COORD_BITS-1:0]        req_height_in,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [COORD_BITS-1:0]             rsp_x_out,
   output logic signed [COORD_BITS-1:0]             rsp_y_out,
   output logic [COORD_BITS-2:0]                    rsp_width_out,
   output logic [COORD_BITS-2:0]                    rsp_height_out,
   output logic                                     rsp_saturated
);

   import apbt_pkg::*;

   localparam int LO_BITS = COORD_BITS / 2;
   localparam int HI_BITS = COORD_BITS - LO_BITS;
   localparam int PH_BITS = COORD_BITS + HI_BITS;
   localparam int PL_BITS = COORD_BITS + LO_BITS + 1;
   localparam int WIDE    = 2 * COORD_BITS + 4;
   localparam int NPROD   = 8;
   localparam int NSTAGE  = 5;

   localparam logic signed [WIDE-1:0] CRD_MAX =
      $signed((WIDE'(1) << (COORD_BITS - 1)) - WIDE'(1));
   localparam logic signed [WIDE-1:0] CRD_MIN = ~CRD_MAX;
   localparam logic [COORD_BITS-1:0]  ONE     = COORD_BITS'(1) << FRAC_BITS;

   // csr registers
   logic signed [COORD_BITS-1:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic signed [COORD_BITS-1:0] shift_x_ff, shift_y_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff  <= ONE;
         coef_b_ff  <= '0;
         coef_c_ff  <= '0;
         coef_d_ff  <= ONE;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            REG_COEF_A:  coef_a_ff  <= csr_data;
            REG_COEF_B:  coef_b_ff  <= csr_data;
            REG_COEF_C:  coef_c_ff  <= csr_data;
            REG_COEF_D:  coef_d_ff  <= csr_data;
            REG_SHIFT_X: shift_x_ff <= csr_data;
            REG_SHIFT_Y: shift_y_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline control
   logic              advance;
   logic [NSTAGE-1:0] vld_ff;
   opcode_type        op_ff [NSTAGE];
   logic              rsp_valid_ff;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= {vld_ff[NSTAGE-2:0], req_valid};
         rsp_valid_ff <= vld_ff[NSTAGE-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op_ff[0] <= opcode_type'(req_opcode);
         for (int s = 1; s < NSTAGE; s++) begin
            op_ff[s] <= op_ff[s-1];
         end
      end
   end

   // stage 1: split multiplies
   logic signed [COORD_BITS-1:0] mul_k [NPROD];
   logic signed [COORD_BITS-1:0] mul_v [NPROD];
   logic signed [PH_BITS-1:0]    ph_in [NPROD];
   logic signed [PH_BITS-1:0]    ph_ff [NPROD];
   logic signed [PL_BITS-1:0]    pl_in [NPROD];
   logic signed [PL_BITS-1:0]    pl_ff [NPROD];

   always_comb begin
      mul_k[0] = coef_a_ff;  mul_v[0] = req_x_in;
      mul_k[1] = coef_c_ff;  mul_v[1] = req_y_in;
      mul_k[2] = coef_b_ff;  mul_v[2] = req_x_in;
      mul_k[3] = coef_d_ff;  mul_v[3] = req_y_in;
      mul_k[4] = coef_a_ff;  mul_v[4] = req_width_in;
      mul_k[5] = coef_b_ff;  mul_v[5] = req_width_in;
      mul_k[6] = coef_c_ff;  mul_v[6] = req_height_in;
      mul_k[7] = coef_d_ff;  mul_v[7] = req_height_in;
   end

   // stage 2: combine partials, floor to fraction width
   logic signed [WIDE-1:0] prod_in [NPROD];
   logic signed [WIDE-1:0] prod_ff [NPROD];

   for (genvar i = 0; i < NPROD; i++) begin : g_mul
      assign ph_in[i] = mul_k[i] * $signed(mul_v[i][COORD_BITS-1:LO_BITS]);
      assign pl_in[i] = mul_k[i] * $signed({1'b0, mul_v[i][LO_BITS-1:0]});
      assign prod_in[i] =
         ((WIDE'(ph_ff[i]) <<< LO_BITS) + WIDE'(pl_ff[i])) >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < NPROD; i++) begin
            ph_ff[i]   <= ph_in[i];
            pl_ff[i]   <= pl_in[i];
            prod_ff[i] <= prod_in[i];
         end
      end
   end

   // stage 3: linear part, plus translation except for distances
   logic signed [WIDE-1:0] px_in, py_in, px_ff, py_ff;
   logic signed [WIDE-1:0] ex_ff, ey_ff, fx_ff, fy_ff;

   always_comb begin
      px_in = prod_ff[0] + prod_ff[1];
      py_in = prod_ff[2] + prod_ff[3];
      if (op_ff[1] != OP_DIST) begin
         px_in = px_in + WIDE'(shift_x_ff);
         py_in = py_in + WIDE'(shift_y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         px_ff <= px_in;
         py_ff <= py_in;
         ex_ff <= prod_ff[4];
         ey_ff <= prod_ff[5];
         fx_ff <= prod_ff[6];
         fy_ff <= prod_ff[7];
      end
   end

   // stage 4: box corners
   logic signed [WIDE-1:0] cx_in [4];
   logic signed [WIDE-1:0] cy_in [4];
   logic signed [WIDE-1:0] cx_ff [4];
   logic signed [WIDE-1:0] cy_ff [4];

   always_comb begin
      cx_in[0] = px_ff;
      cx_in[1] = px_ff + ex_ff;
      cx_in[2] = px_ff + fx_ff;
      cx_in[3] = px_ff + ex_ff + fx_ff;
      cy_in[0] = py_ff;
      cy_in[1] = py_ff + ey_ff;
      cy_in[2] = py_ff + fy_ff;
      cy_in[3] = py_ff + ey_ff + fy_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff <= cx_in;
         cy_ff <= cy_in;
      end
   end

   // stage 5: bounding box; non-box requests collapse to the mapped point
   logic signed [WIDE-1:0] lox_in, hix_in, loy_in, hiy_in;
   logic signed [WIDE-1:0] lox_ff, hix_ff, loy_ff, hiy_ff;
   logic signed [WIDE-1:0] lx0, lx1, hx0, hx1, ly0, ly1, hy0, hy1;

   always_comb begin
      lx0 = (cx_ff[1] < cx_ff[0]) ? cx_ff[1] : cx_ff[0];
      lx1 = (cx_ff[3] < cx_ff[2]) ? cx_ff[3] : cx_ff[2];
      hx0 = (cx_ff[0] < cx_ff[1]) ? cx_ff[1] : cx_ff[0];
      hx1 = (cx_ff[2] < cx_ff[3]) ? cx_ff[3] : cx_ff[2];
      ly0 = (cy_ff[1] < cy_ff[0]) ? cy_ff[1] : cy_ff[0];
      ly1 = (cy_ff[3] < cy_ff[2]) ? cy_ff[3] : cy_ff[2];
      hy0 = (cy_ff[0] < cy_ff[1]) ? cy_ff[1] : cy_ff[0];
      hy1 = (cy_ff[2] < cy_ff[3]) ? cy_ff[3] : cy_ff[2];
      if (op_ff[3] == OP_BOX) begin
         lox_in = (lx1 < lx0) ? lx1 : lx0;
         hix_in = (hx0 < hx1) ? hx1 : hx0;
         loy_in = (ly1 < ly0) ? ly1 : ly0;
         hiy_in = (hy0 < hy1) ? hy1 : hy0;
      end else begin
         lox_in = cx_ff[0];
         hix_in = cx_ff[0];
         loy_in = cy_ff[0];
         hiy_in = cy_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lox_ff <= lox_in;
         hix_ff <= hix_in;
         loy_ff <= loy_in;
         hiy_ff <= hiy_in;
      end
   end

   // stage 6: size and saturation into the response register
   logic signed [WIDE-1:0]       dx, dy;
   logic                         sx_hi, sx_lo, sy_hi, sy_lo, sw, sh;
   logic signed [COORD_BITS-1:0] x_out_in, y_out_in;
   logic [COORD_BITS-2:0]        w_out_in, h_out_in;
   logic                         sat_in;
   logic signed [COORD_BITS-1:0] x_out_ff, y_out_ff;
   logic [COORD_BITS-2:0]        w_out_ff, h_out_ff;
   logic                         sat_ff;

   always_comb begin
      dx    = hix_ff - lox_ff;
      dy    = hiy_ff - loy_ff;
      sx_hi = lox_ff > CRD_MAX;
      sx_lo = lox_ff < CRD_MIN;
      sy_hi = loy_ff > CRD_MAX;
      sy_lo = loy_ff < CRD_MIN;
      sw    = dx > CRD_MAX;
      sh    = dy > CRD_MAX;
      x_out_in = sx_hi ? CRD_MAX[COORD_BITS-1:0] :
                 sx_lo ? CRD_MIN[COORD_BITS-1:0] : lox_ff[COORD_BITS-1:0];
      y_out_in = sy_hi ? CRD_MAX[COORD_BITS-1:0] :
                 sy_lo ? CRD_MIN[COORD_BITS-1:0] : loy_ff[COORD_BITS-1:0];
      w_out_in = sw ? CRD_MAX[COORD_BITS-2:0] : dx[COORD_BITS-2:0];
      h_out_in = sh ? CRD_MAX[COORD_BITS-2:0] : dy[COORD_BITS-2:0];
      sat_in   = sx_hi || sx_lo || sy_hi || sy_lo || sw || sh;
      if (op_ff[4] == OP_NONE) begin
         x_out_in = '0;
         y_out_in = '0;
         w_out_in = '0;
         h_out_in = '0;
         sat_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_out_ff <= x_out_in;
         y_out_ff <= y_out_in;
         w_out_ff <= w_out_in;
         h_out_ff <= h_out_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_x_out      = x_out_ff;
   assign rsp_y_out      = y_out_ff;
   assign rsp_width_out  = w_out_ff;
   assign rsp_height_out = h_out_ff;
   assign rsp_saturated  = sat_ff;

   // checks
   `APBT_ASSERT_NEXT(a_stall_freezes, rsp_valid_ff && rsp_stall, $stable(vld_ff) && rsp_valid_ff, "pipeline moved under stall")
   `APBT_ASSERT_NEXT(a_none_zero, vld_ff[NSTAGE-1] && advance && op_ff[NSTAGE-1] == OP_NONE, rsp_x_out == '0 && rsp_y_out == '0 && !rsp_saturated, "unused opcode gave nonzero response")
   `APBT_ASSERT_NEXT(a_nonbox_size, vld_ff[NSTAGE-1] && advance && op_ff[NSTAGE-1] != OP_BOX, rsp_width_out == '0 && rsp_height_out == '0, "size nonzero for non-box request")
   `APBT_ASSERT_NOW(a_box_order, vld_ff[NSTAGE-1], hix_ff >= lox_ff && hiy_ff >= loy_ff, "box max below min")

endmodule

`default_nettype wire
